FILE: design/tnt_pkg.sv
// ----------------------------------------------------------------------------
// tnt_pkg
// Shared types, sizes and codes of the task notification table.
// ----------------------------------------------------------------------------
package tnt_pkg;

  localparam int NUM_TASKS   = 16;
  localparam int COUNT_WIDTH = 16;
  localparam int TASK_W      = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  localparam logic [2:0] OP_NOTIFY = 3'd0;
  localparam logic [2:0] OP_TAKE   = 3'd1;
  localparam logic [2:0] OP_WAIT   = 3'd2;
  localparam logic [2:0] OP_CLEAR  = 3'd3;
  localparam logic [2:0] OP_PEEK   = 3'd4;

  localparam logic [1:0] ACT_SET_BITS  = 2'd0;
  localparam logic [1:0] ACT_INCREMENT = 2'd1;
  localparam logic [1:0] ACT_OVERWRITE = 2'd2;
  localparam logic [1:0] ACT_OVW_EMPTY = 2'd3;

  localparam logic [1:0] CM_NONE  = 2'd0;
  localparam logic [1:0] CM_ENTRY = 2'd1;
  localparam logic [1:0] CM_EXIT  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_PENDING = 2'd1;
  localparam logic [1:0] ST_NONE    = 2'd2;
  localparam logic [1:0] ST_BLOCKED = 2'd3;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [3:0]  task_req;
    logic [31:0] value;
    logic [1:0]  action;
    logic [1:0]  clr_sel;
  } tnt_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data;
    logic        pend_flag;
    logic        woke_task;
  } tnt_out_t;

  typedef struct packed {
    logic [31:0]            value;
    logic [COUNT_WIDTH-1:0] count;
  } tnt_entry_t;

  typedef struct packed {
    logic load;
    logic read;
    logic exec;
  } tnt_cmd_t;

endpackage

FILE: design/tnt_ctrl.sv
// ----------------------------------------------------------------------------
// tnt_ctrl
// Sequencer: capture a request word, read its table entry, execute and
// write back, and hand the result word to the output register.
// ----------------------------------------------------------------------------
module tnt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tnt_pkg::tnt_cmd_t cmd_o
);
  import tnt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       accept;
  logic       exec;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) || ((state_q == S_EXEC) && out_free);
  assign accept     = in_valid_i && in_ready_o;
  assign exec       = (state_q == S_EXEC) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_READ;
      end
      S_READ: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) state_d = accept ? S_READ : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // load a fresh result, else drop the one taken
  assign out_valid_d = exec ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o.load  = accept;
  assign cmd_o.read  = (state_q == S_READ);
  assign cmd_o.exec  = exec;

endmodule

FILE: design/tnt_datapath.sv
// ----------------------------------------------------------------------------
// tnt_datapath
// Notification table storage, entry update logic and the result register.
// ----------------------------------------------------------------------------
module tnt_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tnt_pkg::tnt_cmd_t cmd_i,
  input  tnt_pkg::tnt_in_t  in_data_i,
  output tnt_pkg::tnt_out_t out_data_o
);
  import tnt_pkg::*;

  tnt_entry_t           mem [NUM_TASKS];
  logic [NUM_TASKS-1:0] vld_q;
  logic [NUM_TASKS-1:0] blk_q, blk_d;

  tnt_in_t    req_q;
  tnt_entry_t rd_q;
  logic       rd_vld_q;
  tnt_out_t   out_q, out_d;

  logic [TASK_W-1:0]      idx;
  logic                   in_range;
  logic [31:0]            prev;
  logic [COUNT_WIDTH-1:0] cnt;
  logic                   nonzero;
  logic                   blk;
  logic [31:0]            new_val;
  logic [COUNT_WIDTH-1:0] new_cnt;
  logic                   new_blk;
  logic                   wr_en;

  assign idx      = TASK_W'(req_q.task_req);
  assign in_range = int'(req_q.task_req) < NUM_TASKS;
  assign prev     = rd_vld_q ? rd_q.value : 32'd0;
  assign cnt      = rd_vld_q ? rd_q.count : '0;
  assign nonzero  = (cnt != '0);
  assign blk      = blk_q[idx];

  always_comb begin
    new_val = prev;
    new_cnt = cnt;
    new_blk = blk;
    out_d   = '0;
    wr_en   = 1'b0;
    if (req_q.opcode <= OP_PEEK) begin
      if (!in_range) begin
        out_d.status = ST_NONE;
      end else begin
        wr_en = 1'b1;
        unique case (req_q.opcode)
          OP_NOTIFY: begin
            out_d.data = prev;
            if ((req_q.action == ACT_OVW_EMPTY) && nonzero) begin
              out_d.status = ST_PENDING;
            end else begin
              unique case (req_q.action)
                ACT_SET_BITS:  new_val = prev | req_q.value;
                ACT_INCREMENT: new_val = prev + req_q.value;
                default:       new_val = req_q.value;
              endcase
              if (cnt != COUNT_MAX) new_cnt = cnt + COUNT_WIDTH'(1);
              if (blk) begin
                new_blk         = 1'b0;
                out_d.woke_task = 1'b1;
              end
            end
          end
          OP_TAKE: begin
            if (nonzero) begin
              out_d.data = prev;
              new_cnt    = cnt - COUNT_WIDTH'(1);
              if ((req_q.clr_sel == CM_ENTRY) || (req_q.clr_sel == CM_EXIT)) begin
                new_val = 32'd0;
              end
            end else begin
              out_d.status = ST_NONE;
            end
          end
          OP_WAIT: begin
            if (req_q.clr_sel == CM_ENTRY) begin
              new_val      = 32'd0;
              new_cnt      = '0;
              new_blk      = 1'b1;
              out_d.status = ST_BLOCKED;
            end else if (nonzero) begin
              out_d.data = prev;
              new_cnt    = cnt - COUNT_WIDTH'(1);
              if (req_q.clr_sel == CM_EXIT) new_val = 32'd0;
            end else begin
              new_blk      = 1'b1;
              out_d.status = ST_BLOCKED;
            end
          end
          OP_CLEAR: begin
            out_d.data = prev;
            new_val    = 32'd0;
            new_cnt    = '0;
          end
          default: begin
            out_d.data = prev;
          end
        endcase
        out_d.pend_flag = (new_cnt != '0);
      end
    end
  end

  always_comb begin
    blk_d = blk_q;
    if (cmd_i.exec && wr_en) blk_d[idx] = new_blk;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      blk_q <= '0;
    end else begin
      blk_q <= blk_d;
      if (cmd_i.exec && wr_en) vld_q[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      mem[idx] <= '{value: new_val, count: new_cnt};
    end
    if (cmd_i.read) begin
      rd_q     <= mem[idx];
      rd_vld_q <= vld_q[idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= in_data_i;
    if (cmd_i.exec) out_q <= out_d;
  end

  assign out_data_o = out_q;

endmodule

FILE: design/task_notification_table.sv
// ----------------------------------------------------------------------------
// task_notification_table
// A request word is registered, its entry read, and once the output is free
// it writes back and registers its result. New requests are taken at that
// write-back or while idle, even as the previous result waits at the output.
// Reset clears all values, counts and blocked flags at once; no clearing pass.
// ----------------------------------------------------------------------------
module task_notification_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tnt_pkg::tnt_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tnt_pkg::tnt_out_t out_data_o
);
  import tnt_pkg::*;

  tnt_cmd_t cmd;

  tnt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  tnt_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

FILE: verif/tnt_checker.sv
// ----------------------------------------------------------------------------
// tnt_checker
// Watches both word channels of the task notification table, keeps its own
// copy of every task's value, pending count and blocked flag, works out the
// result word of each accepted request and compares it field by field with
// the result words that come out, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tnt_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  tnt_pkg::tnt_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  tnt_pkg::tnt_out_t out_data_i,
  output int                mismatches_o,
  output int                outstanding_o
);
  import tnt_pkg::*;

  logic [31:0]            note_val [NUM_TASKS];
  logic [COUNT_WIDTH-1:0] pend_cnt [NUM_TASKS];
  logic                   blocked  [NUM_TASKS];

  tnt_out_t due_results [$];
  tnt_out_t want_word;
  int       mismatch_cnt = 0;
  int       word_idx     = 0;

  function automatic tnt_out_t exec_request(tnt_in_t rq);
    tnt_out_t    r;
    logic [31:0] prev;
    int          t;
    r = '0;
    t = rq.task_req;
    if (rq.opcode > OP_PEEK) return r;
    if (t >= NUM_TASKS) begin
      r.status = ST_NONE;
      return r;
    end
    prev = note_val[t];
    case (rq.opcode)
      OP_NOTIFY: begin
        if (rq.action == ACT_OVW_EMPTY && pend_cnt[t] != '0) begin
          r.status = ST_PENDING;
          r.data   = prev;
        end else begin
          case (rq.action)
            ACT_SET_BITS:  note_val[t] = prev | rq.value;
            ACT_INCREMENT: note_val[t] = prev + rq.value;
            default:       note_val[t] = rq.value;
          endcase
          if (pend_cnt[t] != COUNT_MAX) pend_cnt[t] = pend_cnt[t] + 1'b1;
          if (blocked[t]) begin
            blocked[t]  = 1'b0;
            r.woke_task = 1'b1;
          end
          r.data = prev;
        end
      end
      OP_TAKE: begin
        if (pend_cnt[t] != '0) begin
          r.data      = prev;
          pend_cnt[t] = pend_cnt[t] - 1'b1;
          if (rq.clr_sel == CM_ENTRY || rq.clr_sel == CM_EXIT) note_val[t] = '0;
        end else begin
          r.status = ST_NONE;
        end
      end
      OP_WAIT: begin
        if (rq.clr_sel == CM_ENTRY) begin
          note_val[t] = '0;
          pend_cnt[t] = '0;
        end
        if (pend_cnt[t] != '0) begin
          r.data      = note_val[t];
          pend_cnt[t] = pend_cnt[t] - 1'b1;
          if (rq.clr_sel == CM_EXIT) note_val[t] = '0;
        end else begin
          blocked[t] = 1'b1;
          r.status   = ST_BLOCKED;
        end
      end
      OP_CLEAR: begin
        r.data      = prev;
        note_val[t] = '0;
        pend_cnt[t] = '0;
      end
      default: r.data = prev;
    endcase
    r.pend_flag = (pend_cnt[t] != '0);
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] seen);
    $display("%0t: result word %0d: %s want %h got %h", $realtime, word_idx, field,
             want, seen);
    mismatch_cnt++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        note_val[i] = '0;
        pend_cnt[i] = '0;
        blocked[i]  = 1'b0;
      end
      due_results.delete();
      mismatches_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (due_results.size() == 0) begin
          report_mismatch("unexpected word, data", '0, out_data_i.data);
        end else begin
          want_word = due_results.pop_front();
          if (out_data_i.status !== want_word.status)
            report_mismatch("status", 32'(want_word.status), 32'(out_data_i.status));
          if (out_data_i.data !== want_word.data)
            report_mismatch("data", want_word.data, out_data_i.data);
          if (out_data_i.pend_flag !== want_word.pend_flag)
            report_mismatch("pend_flag", 32'(want_word.pend_flag),
                            32'(out_data_i.pend_flag));
          if (out_data_i.woke_task !== want_word.woke_task)
            report_mismatch("woke_task", 32'(want_word.woke_task),
                            32'(out_data_i.woke_task));
        end
        word_idx++;
      end
      if (in_valid_i && in_ready_i) due_results.push_back(exec_request(in_data_i));
      mismatches_o  <= mismatch_cnt;
      outstanding_o <= due_results.size();
    end
  end

endmodule

FILE: verif/tb_task_notification_table.sv
// ----------------------------------------------------------------------------
// tb_task_notification_table
// Drives request words into the task notification table: a directed run over
// every operation, notify action and clear mode, a notify burst on one task,
// and random traffic focused on a few tasks, under three idle and stall
// mixes. A checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_task_notification_table;
  import tnt_pkg::*;

  localparam logic [1:0] CM_RSVD     = 2'd3;
  localparam int         PHASE_ITEMS = 366;
  localparam int         BURST_ITEMS = 20;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  tnt_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  tnt_out_t out_data;
  int       mismatches;
  int       outstanding;
  int       gap_pct   = 0;
  int       stall_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task_notification_table dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  tnt_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .mismatches_o (mismatches),
    .outstanding_o(outstanding)
  );

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic tnt_in_t make_word(logic [2:0] op, logic [3:0] tsk,
                                        logic [31:0] val, logic [1:0] act,
                                        logic [1:0] cm);
    tnt_in_t w;
    w.opcode   = op;
    w.task_req = tsk;
    w.value    = val;
    w.action   = act;
    w.clr_sel  = cm;
    return w;
  endfunction

  function automatic tnt_in_t rand_word();
    tnt_in_t w;
    int      pick;
    pick = $urandom_range(0, 99);
    if (pick < 36)      w.opcode = OP_NOTIFY;
    else if (pick < 56) w.opcode = OP_TAKE;
    else if (pick < 76) w.opcode = OP_WAIT;
    else if (pick < 84) w.opcode = OP_CLEAR;
    else if (pick < 94) w.opcode = OP_PEEK;
    else                w.opcode = OP_PEEK + 3'($urandom_range(1, 3));
    w.task_req = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, 3))
                                             : 4'($urandom_range(0, 15));
    case ($urandom_range(0, 3))
      0:       w.value = '0;
      1:       w.value = '1;
      2:       w.value = 32'($urandom_range(0, 15));
      default: w.value = $urandom();
    endcase
    w.action  = 2'($urandom_range(0, 3));
    w.clr_sel = 2'($urandom_range(0, 3));
    return w;
  endfunction

  // enter and leave at a falling edge; valid stays high for a following word
  task automatic send_word(input tnt_in_t w);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_random(input int n_items);
    for (int n = 0; n < n_items; n++) begin
      if ($urandom_range(0, 99) == 0) hold_until_drained();
      send_word(rand_word());
    end
  endtask

  initial begin
    #6_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    gap_pct   = 21;
    stall_pct = 83;
    send_word(make_word(OP_PEEK,   4'd0,  '0,           ACT_SET_BITS,  CM_NONE));
    send_word(make_word(OP_TAKE,   4'd0,  '0,           ACT_SET_BITS,  CM_NONE));
    send_word(make_word(OP_NOTIFY, 4'd0,  '1,           ACT_SET_BITS,  CM_NONE));
    send_word(make_word(OP_NOTIFY, 4'd0,  32'h12345678, ACT_OVW_EMPTY, CM_NONE));
    send_word(make_word(OP_NOTIFY, 4'd0,  32'd1,        ACT_INCREMENT, CM_NONE));
    send_word(make_word(OP_TAKE,   4'd0,  '0,           ACT_SET_BITS,  CM_EXIT));
    send_word(make_word(OP_TAKE,   4'd0,  '0,           ACT_SET_BITS,  CM_ENTRY));
    send_word(make_word(OP_TAKE,   4'd0,  '0,           ACT_SET_BITS,  CM_NONE));
    send_word(make_word(OP_NOTIFY, 4'd0,  32'h89ABCDEF, ACT_OVW_EMPTY, CM_NONE));
    send_word(make_word(OP_TAKE,   4'd0,  '0,           ACT_SET_BITS,  CM_RSVD));
    send_word(make_word(OP_WAIT,   4'd1,  '0,           ACT_SET_BITS,  CM_NONE));
    send_word(make_word(OP_NOTIFY, 4'd1,  32'hA5A5A5A5, ACT_OVERWRITE, CM_NONE));
    send_word(make_word(OP_NOTIFY, 4'd1,  32'h5A5A5A5A, ACT_SET_BITS,  CM_NONE));
    send_word(make_word(OP_WAIT,   4'd1,  '0,           ACT_SET_BITS,  CM_EXIT));
    send_word(make_word(OP_WAIT,   4'd1,  '0,           ACT_SET_BITS,  CM_RSVD));
    send_word(make_word(OP_WAIT,   4'd1,  '0,           ACT_SET_BITS,  CM_NONE));
    send_word(make_word(OP_NOTIFY, 4'd15, '1,           ACT_INCREMENT, CM_NONE));
    send_word(make_word(OP_WAIT,   4'd15, '0,           ACT_SET_BITS,  CM_ENTRY));
    send_word(make_word(OP_NOTIFY, 4'd15, '0,           ACT_OVW_EMPTY, CM_NONE));
    send_word(make_word(OP_CLEAR,  4'd15, '0,           ACT_SET_BITS,  CM_NONE));
    send_word(make_word(OP_PEEK,   4'd15, '0,           ACT_SET_BITS,  CM_NONE));
    for (int k = 1; k <= 3; k++)
      send_word(make_word(OP_PEEK + 3'(k), 4'($urandom_range(0, 15)), $urandom(),
                          2'($urandom_range(0, 3)), 2'($urandom_range(0, 3))));

    run_random(PHASE_ITEMS);
    hold_until_drained();

    gap_pct   = 83;
    stall_pct = 21;
    run_random(PHASE_ITEMS);
    hold_until_drained();

    gap_pct   = 0;
    stall_pct = 0;
    // build up a count on one task
    for (int n = 0; n < BURST_ITEMS; n++)
      send_word(make_word(OP_NOTIFY, 4'd6, $urandom(), 2'($urandom_range(0, 2)), CM_NONE));
    send_word(make_word(OP_PEEK,   4'd6, '0,           ACT_SET_BITS,  CM_NONE));
    send_word(make_word(OP_NOTIFY, 4'd6, 32'h0F0F0F0F, ACT_OVW_EMPTY, CM_NONE));
    send_word(make_word(OP_TAKE,   4'd6, '0,           ACT_SET_BITS,  CM_NONE));
    send_word(make_word(OP_WAIT,   4'd6, '0,           ACT_SET_BITS,  CM_ENTRY));
    send_word(make_word(OP_NOTIFY, 4'd6, 32'h0F0F0F0F, ACT_INCREMENT, CM_NONE));
    run_random(PHASE_ITEMS);

    in_valid <= 1'b0;
    for (int i = 0; i < 5000 && outstanding != 0; i++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
design/tnt_pkg.sv
design/tnt_ctrl.sv
design/tnt_datapath.sv
design/task_notification_table.sv
verif/tnt_checker.sv
verif/tb_task_notification_table.sv
